// ----- rtl/hamming_29_24_codec_core_assert.svh -----
// Assertion helpers for the Hamming (29,24) codec core.
`ifndef HAMMING_29_24_CODEC_CORE_ASSERT_SVH
`define HAMMING_29_24_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HAM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ham2924_pkg.sv -----
package ham2924_pkg;

    localparam int WORD_W     = 29;
    localparam int DATA_W     = 24;
    localparam int SYN_W      = 5;
    localparam int NUM_CHECKS = 5;

    localparam logic [SYN_W-1:0] WORD_BITS = 5'd29;

    // Data positions covered by each check bit (check bits themselves excluded)
    localparam logic [NUM_CHECKS-1:0][WORD_W-1:0] CHECK_MASK = '{
        29'h1FFF0000,
        29'h1F807F00,
        29'h18787870,
        29'h06666664,
        29'h15555554
    };

    localparam logic [NUM_CHECKS-1:0][SYN_W-1:0] CHECK_BIT = '{
        5'd15, 5'd7, 5'd3, 5'd1, 5'd0
    };

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [WORD_W-1:0] word_in;
    } in_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [SYN_W-1:0]  syndrome;
    } out_t;

endpackage

// ----- rtl/hamming_29_24_codec_core.sv -----
// Hamming (29,24) single-error-correcting codec. Each transaction either
// encodes the low 24 bits of word_in into a 29-bit code word (check bits at
// bits 0, 1, 3, 7 and 15, syndrome reported as zero) or decodes a code word,
// corrects the single bit named by the syndrome and returns the 24 data bits
// with the syndrome; syndromes 30 and 31 leave the data as received, and a
// double error is not detected. One transaction is accepted every cycle while
// the result side does not stall; the input register takes it on acceptance
// and the result register takes it from there, and the result is valid once
// it sits in the result register. A stall on the result side backs up through
// both registers.
`include "hamming_29_24_codec_core_assert.svh"

module hamming_29_24_codec_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ham2924_pkg::in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ham2924_pkg::out_t m_data
);
    import ham2924_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    in_t  s1_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_reg;
    out_t out_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = s1_valid_reg;
        end
        if (s_ready) begin
            s1_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_reg <= s_data;
        end
        if (out_free && s1_valid_reg) begin
            out_reg <= out_next;
        end
    end

    // Codec datapath
    logic [DATA_W-1:0] enc_data;
    logic [WORD_W-1:0] enc_scatter;
    logic [WORD_W-1:0] enc_word;
    logic [WORD_W-1:0] dec_word;
    logic [SYN_W-1:0]  dec_syn;
    logic [WORD_W-1:0] dec_fixed;
    logic [DATA_W-1:0] dec_data;

    always_comb begin
        enc_data              = s1_reg.word_in[DATA_W-1:0];
        enc_scatter           = '0;
        enc_scatter[2]        = enc_data[0];
        enc_scatter[6:4]      = enc_data[3:1];
        enc_scatter[14:8]     = enc_data[10:4];
        enc_scatter[28:16]    = enc_data[23:11];
        enc_word              = enc_scatter;
        for (int k = 0; k < NUM_CHECKS; k++) begin
            enc_word[CHECK_BIT[k]] = ^(enc_scatter & CHECK_MASK[k]);
        end
    end

    always_comb begin
        dec_word = s1_reg.word_in;
        for (int k = 0; k < NUM_CHECKS; k++) begin
            dec_syn[k] = (^(dec_word & CHECK_MASK[k])) ^ dec_word[CHECK_BIT[k]];
        end
        dec_fixed = dec_word;
        // syndromes past the top bit name no position
        if (dec_syn != '0 && dec_syn <= WORD_BITS) begin
            dec_fixed = dec_word ^ (WORD_W'(1) << 5'(dec_syn - 5'd1));
        end
        dec_data[0]     = dec_fixed[2];
        dec_data[3:1]   = dec_fixed[6:4];
        dec_data[10:4]  = dec_fixed[14:8];
        dec_data[23:11] = dec_fixed[28:16];
    end

    always_comb begin
        case (s1_reg.operation)
            OP_ENCODE: begin
                out_next.word_out = enc_word;
                out_next.syndrome = '0;
            end
            OP_DECODE: begin
                out_next.word_out = {{(WORD_W-DATA_W){1'b0}}, dec_data};
                out_next.syndrome = dec_syn;
            end
            default: begin
                out_next.word_out = '0;
                out_next.syndrome = '0;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `HAM_ASSERT_NOW(a_dec_high_zero, aclk, aresetn,
        m_valid && (m_data.syndrome != '0), m_data.word_out[WORD_W-1:DATA_W] == '0,
        "decode result has high bits set")
    `HAM_ASSERT_NEXT(a_s1_hold, aclk, aresetn,
        s1_valid_reg && !out_free, s1_valid_reg && $stable(s1_reg),
        "input stage changed while stalled")
    `HAM_ASSERT_NEXT(a_s1_advance, aclk, aresetn,
        s1_valid_reg && out_free, m_valid,
        "input stage item lost on advance")

endmodule

// ----- verif/hamming_result_monitor.sv -----
`timescale 1ns / 1ps

package ham2924_tb_pkg;
    import ham2924_pkg::*;

    // Data positions covered by each check bit, check bit k at index k
    localparam logic [4:0][28:0] COVER_MASK = {
        29'h1FFF0000, 29'h1F807F00, 29'h18787870, 29'h06666664, 29'h15555554
    };
    localparam logic [4:0][4:0] CHECK_SLOT = {5'd15, 5'd7, 5'd3, 5'd1, 5'd0};

    function automatic out_t codec_result(input op_t op, input logic [28:0] word);
        logic [28:0] w;
        logic [23:0] d;
        logic [4:0]  syn;
        out_t        r;
        w   = word;
        syn = '0;
        if (op == OP_ENCODE) begin
            d = w[23:0];
            w = {d[23:11], 1'b0, d[10:4], 1'b0, d[3:1], 1'b0, d[0], 2'b00};
            for (int k = 0; k < 5; k++) begin
                if (^(w & COVER_MASK[k]))
                    w[CHECK_SLOT[k]] = 1'b1;
            end
            r.word_out = w;
        end else begin
            for (int k = 0; k < 5; k++)
                syn[k] = (^(w & COVER_MASK[k])) ^ w[CHECK_SLOT[k]];
            // 30 and 31 point past the top of the word: nothing to correct
            if (syn != 5'd0 && syn <= 5'd29)
                w[syn - 5'd1] = ~w[syn - 5'd1];
            r.word_out = {5'b0, w[28:16], w[14:8], w[6:4], w[2]};
        end
        r.syndrome = syn;
        return r;
    endfunction
endpackage

module hamming_result_monitor (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ham2924_pkg::in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ham2924_pkg::out_t m_data,
    output int                mismatches,
    output int                results_due
);
    import ham2924_pkg::*;
    import ham2924_tb_pkg::*;

    localparam int MAX_REPORTS = 10;

    out_t awaited_words[$];

    initial begin
        mismatches  = 0;
        results_due = 0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: result mismatch, %s", $time, what);
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction word_out %h syndrome %0d",
                                            m_data.word_out, m_data.syndrome));
                end else begin
                    want = awaited_words.pop_front();
                    if (m_data.word_out !== want.word_out || m_data.syndrome !== want.syndrome)
                        flag_mismatch($sformatf(
                            "expected word_out %h syndrome %0d, got word_out %h syndrome %0d",
                            want.word_out, want.syndrome, m_data.word_out, m_data.syndrome));
                end
            end
            if (s_valid && s_ready)
                awaited_words.push_back(codec_result(s_data.operation, s_data.word_in));
            results_due = awaited_words.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ham2924_pkg::*;
    import ham2924_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 448;
    localparam int LONG_HOLD      = 120;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int mismatches;
    int results_due;
    int send_idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int quiet_cycles;

    hamming_29_24_codec_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    hamming_result_monitor u_result_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested
    always @(negedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Called and returns at a falling edge
    task automatic send_item(input op_t op, input logic [28:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.operation  <= op;
        s_data.word_in    <= word;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    function automatic logic [28:0] clean_word(input logic [23:0] data);
        out_t r;
        r = codec_result(OP_ENCODE, {5'b0, data});
        return r.word_out;
    endfunction

    // Random encodes; decodes mostly of code words with zero, one or two flipped bits, some raw noise
    task automatic send_random();
        int          pick;
        logic [28:0] cw;
        pick = $urandom_range(99);
        cw   = clean_word(24'($urandom));
        if (pick < 40) begin
            send_item(OP_ENCODE, 29'($urandom));
        end else begin
            if (pick >= 55)
                cw[$urandom_range(28)] ^= 1'b1;
            if (pick >= 85)
                cw[$urandom_range(28)] ^= 1'b1;
            if (pick >= 93)
                cw = 29'($urandom);
            send_item(OP_DECODE, cw);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
    endtask

    initial begin
        int          idle_set [4];
        int          stall_set[4];
        logic [28:0] cw;
        idle_set      = '{0, 63, 0, 29};
        stall_set     = '{0, 0, 63, 29};
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Field extremes; high input bits must be ignored on encode
        send_item(OP_ENCODE, 29'h0000000);
        send_item(OP_ENCODE, 29'h0FFFFFF);
        send_item(OP_ENCODE, 29'h1FFFFFF);
        send_item(OP_ENCODE, 29'h1F000000);
        send_item(OP_ENCODE, 29'h0555555);
        send_item(OP_ENCODE, 29'h0AAAAAA);
        send_item(OP_ENCODE, 29'h0000001);
        send_item(OP_ENCODE, 29'h0800000);
        send_item(OP_DECODE, clean_word(24'hFFFFFF));
        send_item(OP_DECODE, 29'h0000000);
        send_item(OP_DECODE, 29'h1FFFFFFF);
        cw = clean_word(24'hA5C3E1);
        // Errors on each check bit leave the data untouched; then the lowest and highest data bits
        send_item(OP_DECODE, cw ^ 29'h0000001);
        send_item(OP_DECODE, cw ^ 29'h0000002);
        send_item(OP_DECODE, cw ^ 29'h0000008);
        send_item(OP_DECODE, cw ^ 29'h0000080);
        send_item(OP_DECODE, cw ^ 29'h0008000);
        send_item(OP_DECODE, cw ^ 29'h0000004);
        send_item(OP_DECODE, cw ^ 29'h10000000);
        // Positions 14 and 16 give syndrome 30, 15 and 16 give 31
        send_item(OP_DECODE, cw ^ 29'h000A000);
        send_item(OP_DECODE, cw ^ 29'h000C000);
        // Double error: miscorrection expected
        send_item(OP_DECODE, cw ^ 29'h0000030);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph];
            stall_pct     = stall_set[ph];
            if (ph == 0)
                hold_requests++;
            repeat (RANDOM_ITEMS / 4) send_random();
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && results_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- hamming_29_24_codec_core.f -----
+incdir+rtl
rtl/ham2924_pkg.sv
rtl/hamming_29_24_codec_core.sv
verif/hamming_result_monitor.sv
verif/testbench.sv
